### rtl/imdu_pkg.sv
package imdu_pkg;

	// Operand and register width
	localparam int unsigned DataW = 32;

	// Request codes carried on s_tuser
	localparam int unsigned OpW = 3;
	localparam logic [OpW-1:0] OP_MULT_S  = 3'd0;
	localparam logic [OpW-1:0] OP_MULT_U  = 3'd1;
	localparam logic [OpW-1:0] OP_DIV_S   = 3'd2;
	localparam logic [OpW-1:0] OP_DIV_U   = 3'd3;
	localparam logic [OpW-1:0] OP_WRITE_HI = 3'd4;
	localparam logic [OpW-1:0] OP_WRITE_LO = 3'd5;

	// Special operand values
	localparam logic [DataW-1:0] SIGN_BIT = 32'h8000_0000;
	localparam logic [DataW-1:0] ALL_ONES = 32'hFFFF_FFFF;

	// Step counter width for the shift-add multiply and restoring divide
	localparam int unsigned StepCntW = $clog2(DataW);

endpackage

### rtl/integer_multiply_divide_unit_core.sv
// Channel  Dir  Bits  Contents
// s_*      in   64    s_tdata: first_operand, second_operand; s_tuser: req_type
// m_*      out  64    m_tdata: hi_value, lo_value
//
// From acceptance, writes, unused codes, divide by zero and the signed overflow divide
// go straight to the result; multiply and divide run the bit loop, signed multiply
// adds sign fix-up passes after it, and signed divide also takes magnitudes first.
// One 34-bit adder shared by all steps retires one product or quotient bit per cycle.
// Reset clears HI, LO and the sequencer. One word is in flight at a time: s_tready is
// low from acceptance until the cycle after the result is taken on m_*.
module integer_multiply_divide_unit_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] first_operand, [63:32] second_operand
	input  logic [2:0]  s_tuser,   // [2:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // [31:0] hi_value, [63:32] lo_value
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NEG_A,
		ST_NEG_B,
		ST_ITER,
		ST_FIX_A,
		ST_FIX_B,
		ST_DONE
	} state_t;

	localparam int unsigned W = imdu_pkg::DataW;

	state_t state_q;
	logic [W-1:0] hi_q;
	logic [W-1:0] lo_q;
	logic [W-1:0] a_q;
	logic [W-1:0] b_q;
	logic         is_div_q;
	logic         is_signed_q;
	logic         neg_a_q;
	logic         neg_b_q;
	logic [imdu_pkg::StepCntW-1:0] cnt_q;

	logic         accept;
	logic [W-1:0] in_a;
	logic [W-1:0] in_b;
	logic [W:0]   add_a;
	logic [W:0]   add_b;
	logic         add_cin;
	logic [W+1:0] sum;
	logic [W:0]   mul_acc;
	logic         div_keep;

	assign in_a = s_tdata[W-1:0];
	assign in_b = s_tdata[2*W-1:W];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = (state_q == ST_DONE);
	assign m_tdata  = {lo_q, hi_q};

	// Select the shared adder operands for the current step
	always_comb begin
		add_a   = {1'b0, hi_q};
		add_b   = {1'b0, a_q};
		add_cin = 1'b0;
		unique case (state_q)
			ST_NEG_A: begin
				add_a   = '0;
				add_b   = ~{1'b0, lo_q};
				add_cin = 1'b1;
			end
			ST_NEG_B: begin
				add_a   = '0;
				add_b   = ~{1'b0, b_q};
				add_cin = 1'b1;
			end
			ST_ITER: begin
				if (is_div_q) begin
					add_a   = {hi_q, lo_q[W-1]};
					add_b   = ~{1'b0, b_q};
					add_cin = 1'b1;
				end else begin
					add_a   = {1'b0, hi_q};
					add_b   = {1'b0, a_q};
					add_cin = 1'b0;
				end
			end
			ST_FIX_A: begin
				// divide: negate quotient; multiply: subtract b from HI
				if (is_div_q) begin
					add_a = '0;
					add_b = ~{1'b0, lo_q};
				end else begin
					add_a = {1'b0, hi_q};
					add_b = ~{1'b0, b_q};
				end
				add_cin = 1'b1;
			end
			ST_FIX_B: begin
				// divide: negate remainder; multiply: subtract a from HI
				if (is_div_q) begin
					add_a = '0;
					add_b = ~{1'b0, hi_q};
				end else begin
					add_a = {1'b0, hi_q};
					add_b = ~{1'b0, a_q};
				end
				add_cin = 1'b1;
			end
			ST_IDLE, ST_DONE: begin
				add_a   = {1'b0, hi_q};
				add_b   = {1'b0, a_q};
				add_cin = 1'b0;
			end
			default: begin
				add_a   = {1'b0, hi_q};
				add_b   = {1'b0, a_q};
				add_cin = 1'b0;
			end
		endcase
	end

	assign sum      = {1'b0, add_a} + {1'b0, add_b} + {{(W+1){1'b0}}, add_cin};
	assign mul_acc  = lo_q[0] ? sum[W:0] : {1'b0, hi_q};
	assign div_keep = sum[W+1];

	// Sequencer, working operands and HI/LO
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hi_q        <= '0;
			lo_q        <= '0;
			is_div_q    <= 1'b0;
			is_signed_q <= 1'b0;
			neg_a_q     <= 1'b0;
			neg_b_q     <= 1'b0;
			cnt_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						a_q         <= in_a;
						b_q         <= in_b;
						cnt_q       <= '0;
						is_div_q    <= (s_tuser == imdu_pkg::OP_DIV_S) ||
						               (s_tuser == imdu_pkg::OP_DIV_U);
						is_signed_q <= (s_tuser == imdu_pkg::OP_DIV_S) ||
						               (s_tuser == imdu_pkg::OP_MULT_S);
						neg_a_q     <= in_a[W-1];
						neg_b_q     <= in_b[W-1];
						state_q     <= ST_DONE;
						case (s_tuser)
							imdu_pkg::OP_MULT_S, imdu_pkg::OP_MULT_U: begin
								hi_q    <= '0;
								lo_q    <= in_b;
								state_q <= ST_ITER;
							end
							imdu_pkg::OP_DIV_S: begin
								if (in_b == '0) begin
									hi_q <= in_a;
									lo_q <= in_a[W-1] ? W'(1) : imdu_pkg::ALL_ONES;
								end else if (in_a == imdu_pkg::SIGN_BIT &&
								             in_b == imdu_pkg::ALL_ONES) begin
									hi_q <= '0;
									lo_q <= imdu_pkg::SIGN_BIT;
								end else begin
									hi_q    <= '0;
									lo_q    <= in_a;
									state_q <= ST_NEG_A;
								end
							end
							imdu_pkg::OP_DIV_U: begin
								if (in_b == '0) begin
									hi_q <= in_a;
									lo_q <= imdu_pkg::ALL_ONES;
								end else begin
									hi_q    <= '0;
									lo_q    <= in_a;
									state_q <= ST_ITER;
								end
							end
							imdu_pkg::OP_WRITE_HI: hi_q <= in_a;
							imdu_pkg::OP_WRITE_LO: lo_q <= in_a;
							default: ;
						endcase
					end
				end
				// Take magnitudes of dividend and divisor
				ST_NEG_A: begin
					if (neg_a_q) begin
						lo_q <= sum[W-1:0];
					end
					state_q <= ST_NEG_B;
				end
				ST_NEG_B: begin
					if (neg_b_q) begin
						b_q <= sum[W-1:0];
					end
					state_q <= ST_ITER;
				end
				// One product or quotient bit per cycle
				ST_ITER: begin
					if (is_div_q) begin
						hi_q <= div_keep ? sum[W-1:0] : {hi_q[W-2:0], lo_q[W-1]};
						lo_q <= {lo_q[W-2:0], div_keep};
					end else begin
						hi_q <= mul_acc[W:1];
						lo_q <= {mul_acc[0], lo_q[W-1:1]};
					end
					cnt_q <= cnt_q + 1'b1;
					if (&cnt_q) begin
						state_q <= is_signed_q ? ST_FIX_A : ST_DONE;
					end
				end
				// Apply sign corrections
				ST_FIX_A: begin
					if (is_div_q) begin
						if (neg_a_q ^ neg_b_q) begin
							lo_q <= sum[W-1:0];
						end
					end else if (neg_a_q) begin
						hi_q <= sum[W-1:0];
					end
					state_q <= ST_FIX_B;
				end
				ST_FIX_B: begin
					if (is_div_q ? neg_a_q : neg_b_q) begin
						hi_q <= sum[W-1:0];
					end
					state_q <= ST_DONE;
				end
				// Hold the result until taken
				ST_DONE: begin
					if (m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	// A write request lands in HI on the very next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tuser == imdu_pkg::OP_WRITE_HI |=>
			m_tvalid && m_tdata[W-1:0] == $past(in_a))
		else $error("write HI not reflected");

	// Unsigned divide by zero gives an all-ones quotient and dividend remainder
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tuser == imdu_pkg::OP_DIV_U && in_b == '0 |=>
			m_tdata[2*W-1:W] == imdu_pkg::ALL_ONES && m_tdata[W-1:0] == $past(in_a))
		else $error("divide by zero result wrong");

	// HI and LO change only while a request is being worked on
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE && !accept |=> $stable(hi_q) && $stable(lo_q))
		else $error("HI/LO changed while idle");

	// Step counter is at zero whenever the bit loop is entered
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_ITER ##1 state_q == ST_ITER |-> cnt_q == '0)
		else $error("step counter not cleared on loop entry");
`endif

endmodule

### test/tb_integer_multiply_divide_unit_core.sv
`timescale 1ns / 1ps

module tb_integer_multiply_divide_unit_core;

	// Codes past the defined set; the unit must leave HI and LO alone
	localparam logic [imdu_pkg::OpW-1:0] OP_RSVD_6 = 3'd6;
	localparam logic [imdu_pkg::OpW-1:0] OP_RSVD_7 = 3'd7;

	localparam int unsigned IdleLimit = 4000;
	localparam int unsigned SettleCycles = 60;
	localparam int unsigned RandomWords = 1820;

	typedef struct packed {
		logic [imdu_pkg::DataW-1:0] hi;
		logic [imdu_pkg::DataW-1:0] lo;
	} hilo_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;   // [31:0] first_operand, [63:32] second_operand
	logic [2:0]  s_tuser = '0;   // [2:0] req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;        // [31:0] hi_value, [63:32] lo_value

	// Running copy of HI/LO and the words still owed by the unit
	hilo_t       hilo_now;
	hilo_t       hilo_owed[$];
	int unsigned mismatch_cnt = 0;
	int unsigned idle_cycles = 0;

	// Idling controls for sender and receiver
	bit          tx_gap_en = 1'b0;
	bit          rx_stall_en = 1'b0;
	int unsigned tx_burst_left = 0;
	int unsigned rx_run_left = 0;

	logic [imdu_pkg::OpW-1:0] all_ops[8] = '{imdu_pkg::OP_MULT_S, imdu_pkg::OP_MULT_U,
		imdu_pkg::OP_DIV_S, imdu_pkg::OP_DIV_U, imdu_pkg::OP_WRITE_HI,
		imdu_pkg::OP_WRITE_LO, OP_RSVD_6, OP_RSVD_7};

	integer_multiply_divide_unit_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Compute HI/LO after one request
	function automatic hilo_t mdu_next_hilo(hilo_t cur, logic [imdu_pkg::OpW-1:0] op,
			logic [imdu_pkg::DataW-1:0] a, logic [imdu_pkg::DataW-1:0] b);
		hilo_t                      nxt;
		logic [63:0]                prod;
		logic [imdu_pkg::DataW-1:0] mag_a;
		logic [imdu_pkg::DataW-1:0] mag_b;
		logic [imdu_pkg::DataW-1:0] quo;
		logic [imdu_pkg::DataW-1:0] rem;
		nxt = cur;
		case (op)
			imdu_pkg::OP_MULT_S: begin
				// low 64 bits of the sign-extended product
				prod = {{32{a[31]}}, a} * {{32{b[31]}}, b};
				nxt = {prod[63:32], prod[31:0]};
			end
			imdu_pkg::OP_MULT_U: begin
				prod = {32'd0, a} * {32'd0, b};
				nxt = {prod[63:32], prod[31:0]};
			end
			imdu_pkg::OP_DIV_S: begin
				if (b == '0) begin
					nxt.hi = a;
					nxt.lo = a[31] ? 32'd1 : imdu_pkg::ALL_ONES;
				end else if (a == imdu_pkg::SIGN_BIT && b == imdu_pkg::ALL_ONES) begin
					nxt.hi = '0;
					nxt.lo = imdu_pkg::SIGN_BIT;
				end else begin
					// divide magnitudes, then fix the signs
					mag_a = a[31] ? (32'd0 - a) : a;
					mag_b = b[31] ? (32'd0 - b) : b;
					quo = mag_a / mag_b;
					rem = mag_a % mag_b;
					nxt.lo = (a[31] != b[31]) ? (32'd0 - quo) : quo;
					nxt.hi = a[31] ? (32'd0 - rem) : rem;
				end
			end
			imdu_pkg::OP_DIV_U: begin
				if (b == '0) begin
					nxt.hi = a;
					nxt.lo = imdu_pkg::ALL_ONES;
				end else begin
					nxt.hi = a % b;
					nxt.lo = a / b;
				end
			end
			imdu_pkg::OP_WRITE_HI: nxt.hi = a;
			imdu_pkg::OP_WRITE_LO: nxt.lo = a;
			default: nxt = cur;
		endcase
		return nxt;
	endfunction

	// Offer one word at a falling edge; predict once it is taken
	task automatic send_word(logic [imdu_pkg::OpW-1:0] op, logic [imdu_pkg::DataW-1:0] a,
			logic [imdu_pkg::DataW-1:0] b);
		int unsigned gap;
		@(negedge clk);
		if (tx_gap_en && tx_burst_left == 0) begin
			s_tvalid <= 1'b0;
			gap = $urandom_range(1, 40);
			repeat (gap) @(negedge clk);
			tx_burst_left = $urandom_range(1, 8);
		end
		if (tx_burst_left != 0)
			tx_burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {b, a};
		s_tuser <= op;
		do
			@(posedge clk);
		while (!s_tready);
		hilo_now = mdu_next_hilo(hilo_now, op, a, b);
		hilo_owed.push_back(hilo_now);
	endtask

	// Hold the sender until every owed word has come back
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (hilo_owed.size() != 0)
			@(posedge clk);
	endtask

	// Operand with a bias toward edge values
	function automatic logic [imdu_pkg::DataW-1:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return imdu_pkg::ALL_ONES;
			2: return imdu_pkg::SIGN_BIT;
			3: return ~imdu_pkg::SIGN_BIT;
			4: return imdu_pkg::DataW'($urandom_range(1, 16));
			5: return 32'd0 - imdu_pkg::DataW'($urandom_range(1, 16));
			6: return $urandom >> $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [imdu_pkg::OpW-1:0] pick_op();
		if ($urandom_range(0, 29) == 0)
			return all_ops[3'($urandom_range(6, 7))];
		return all_ops[3'($urandom_range(0, 5))];
	endfunction

	task automatic test_multiply();
		send_word(imdu_pkg::OP_MULT_S, imdu_pkg::SIGN_BIT, imdu_pkg::SIGN_BIT);
		send_word(imdu_pkg::OP_MULT_S, imdu_pkg::ALL_ONES, imdu_pkg::ALL_ONES);
		send_word(imdu_pkg::OP_MULT_S, ~imdu_pkg::SIGN_BIT, imdu_pkg::SIGN_BIT);
		send_word(imdu_pkg::OP_MULT_S, imdu_pkg::ALL_ONES, 32'd5);
		send_word(imdu_pkg::OP_MULT_U, imdu_pkg::ALL_ONES, imdu_pkg::ALL_ONES);
		send_word(imdu_pkg::OP_MULT_U, '0, imdu_pkg::ALL_ONES);
		send_word(imdu_pkg::OP_MULT_U, imdu_pkg::SIGN_BIT, 32'd2);
	endtask

	task automatic test_divide();
		// divide by zero, both signs of dividend
		send_word(imdu_pkg::OP_DIV_S, 32'd7, '0);
		send_word(imdu_pkg::OP_DIV_S, imdu_pkg::SIGN_BIT, '0);
		// most negative over minus one
		send_word(imdu_pkg::OP_DIV_S, imdu_pkg::SIGN_BIT, imdu_pkg::ALL_ONES);
		// truncation toward zero, remainder follows dividend
		send_word(imdu_pkg::OP_DIV_S, 32'd0 - 32'd7, 32'd2);
		send_word(imdu_pkg::OP_DIV_S, 32'd7, 32'd0 - 32'd2);
		send_word(imdu_pkg::OP_DIV_S, 32'd0 - 32'd7, 32'd0 - 32'd2);
		send_word(imdu_pkg::OP_DIV_S, imdu_pkg::SIGN_BIT, imdu_pkg::SIGN_BIT);
		send_word(imdu_pkg::OP_DIV_S, 32'd5, imdu_pkg::SIGN_BIT);
		send_word(imdu_pkg::OP_DIV_U, imdu_pkg::ALL_ONES, '0);
		send_word(imdu_pkg::OP_DIV_U, imdu_pkg::ALL_ONES, 32'd1);
		send_word(imdu_pkg::OP_DIV_U, 32'd5, imdu_pkg::ALL_ONES);
		send_word(imdu_pkg::OP_DIV_U, 32'h1234_5678, 32'h10);
	endtask

	task automatic test_writes_and_unused();
		send_word(imdu_pkg::OP_WRITE_HI, imdu_pkg::ALL_ONES, $urandom);
		send_word(imdu_pkg::OP_WRITE_LO, imdu_pkg::ALL_ONES, $urandom);
		send_word(OP_RSVD_6, $urandom, $urandom);
		send_word(OP_RSVD_7, $urandom, $urandom);
		send_word(imdu_pkg::OP_WRITE_HI, '0, imdu_pkg::ALL_ONES);
		send_word(imdu_pkg::OP_WRITE_LO, '0, imdu_pkg::ALL_ONES);
	endtask

	// Single words sent only once the unit has gone quiet
	task automatic test_drained_sends();
		repeat (4) begin
			wait_drained();
			send_word(pick_op(), pick_operand(), pick_operand());
		end
	endtask

	// Random words in chunks, each chunk with its own idling mix
	task automatic test_random();
		int unsigned chunk;
		for (chunk = 0; chunk < 10; chunk++) begin
			if (chunk < 4) begin
				tx_gap_en = chunk[0];
				rx_stall_en = chunk[1];
			end else begin
				tx_gap_en = 1'($urandom_range(0, 1));
				rx_stall_en = 1'($urandom_range(0, 1));
			end
			repeat (RandomWords / 10)
				send_word(pick_op(), pick_operand(), pick_operand());
			if (chunk == 5)
				wait_drained();
		end
	endtask

	// Receiver: alternate ready and stall runs of random length
	always @(negedge clk) begin
		if (!rx_stall_en) begin
			m_tready <= 1'b1;
		end else if (rx_run_left != 0) begin
			rx_run_left <= rx_run_left - 1;
		end else begin
			m_tready <= !m_tready;
			rx_run_left <= m_tready ? $urandom_range(0, 20) : $urandom_range(0, 12);
		end
	end

	// Compare each returned word against the oldest owed one
	always @(posedge clk) begin
		hilo_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (hilo_owed.size() == 0) begin
				$error("m_tdata: word %h arrived with none owed", m_tdata);
				mismatch_cnt++;
			end else begin
				want = hilo_owed.pop_front();
				if (m_tdata[31:0] !== want.hi) begin
					$error("hi_value: expected %h, got %h", want.hi, m_tdata[31:0]);
					mismatch_cnt++;
				end
				if (m_tdata[63:32] !== want.lo) begin
					$error("lo_value: expected %h, got %h", want.lo, m_tdata[63:32]);
					mismatch_cnt++;
				end
			end
		end
	end

	// Watchdog: give up after a long stretch with no word moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		hilo_now = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		test_multiply();
		test_divide();
		test_writes_and_unused();
		test_drained_sends();
		test_random();

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (hilo_owed.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);

		if (mismatch_cnt == 0 && hilo_owed.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### files.f
rtl/imdu_pkg.sv
rtl/integer_multiply_divide_unit_core.sv
test/tb_integer_multiply_divide_unit_core.sv
